[hw/rtl/brct_pkg.sv]
// shared types and constants for the buffer rate clock trim block
`default_nettype none

package brct_pkg;

    localparam int LEVEL_W  = 16;
    localparam int SUM_W    = 24;
    localparam int RATE_W   = SUM_W + 1;
    localparam int BLEN_W   = 8;
    localparam int CNT_W    = BLEN_W + 1;
    localparam int GAIN_W   = 4;
    localparam int PROD_W   = RATE_W + GAIN_W + 1;
    localparam int DAC_W    = 12;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    localparam logic [BLEN_W-1:0] BLEN_RESET  = 8'd100;
    localparam logic [GAIN_W-1:0] GAIN_RESET  = 4'd3;
    localparam int                DRIVE_RESET = 2048;

    typedef enum logic [0:0] {
        REG_BLOCK_LENGTH = 1'b0,
        REG_LOOP_GAIN    = 1'b1
    } brct_reg_t;

endpackage

`default_nettype wire

[hw/rtl/brct_fifo.sv]
// small register queue used between the front, back and result ports
`default_nettype none

module brct_fifo #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/brct_front.sv]
// front end: takes samples, counts and sums them, hands each block sum on
`default_nettype none

module brct_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [brct_pkg::BLEN_W-1:0]        block_length,
    input  wire logic                               push,
    input  wire logic signed [brct_pkg::LEVEL_W-1:0] buffer_level,
    output logic                                    full,
    input  wire logic                               sum_full,
    output logic                                    sum_push,
    output logic [brct_pkg::SUM_W-1:0]              sum_data
);

    import brct_pkg::*;

    logic [BLEN_W-1:0]       count_reg, count_next;
    logic signed [SUM_W-1:0] running_reg, running_next;
    logic signed [SUM_W-1:0] sum_new;
    logic [CNT_W-1:0]        taken;
    logic [CNT_W-1:0]        limit;
    logic                    accept;
    logic                    block_end;

    assign full   = sum_full;
    assign accept = push && !sum_full;

    always_comb
    begin
        taken     = {1'b0, count_reg} + 1'b1;
        // zero length means a full 256-sample block
        limit     = (block_length == '0) ? CNT_W'(1 << BLEN_W) : {1'b0, block_length};
        block_end = (taken >= limit);
        sum_new   = running_reg + SUM_W'(buffer_level);
        sum_push  = accept && block_end;
        sum_data  = sum_new;

        count_next   = count_reg;
        running_next = running_reg;
        if (accept)
        begin
            if (block_end)
            begin
                count_next   = '0;
                running_next = '0;
            end
            else
            begin
                count_next   = taken[BLEN_W-1:0];
                running_next = sum_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            running_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            running_reg <= running_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/brct_back.sv]
// back end: rate from block sums, gain, drive integration and clamp
`default_nettype none

module brct_back #(
    parameter int DRIVE_MAX = 4095
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [brct_pkg::GAIN_W-1:0]  loop_gain,
    input  wire logic                         sum_valid,
    input  wire logic [brct_pkg::SUM_W-1:0]   sum_data,
    output logic                              sum_pop,
    input  wire logic                         res_full,
    output logic                              res_push,
    output logic [brct_pkg::DAC_W-1:0]        res_data
);

    import brct_pkg::*;

    localparam int DRIVE_BITS = $clog2(DRIVE_MAX + 1);
    localparam int DRIVE_W    = (DRIVE_BITS < DAC_W) ? DAC_W : DRIVE_BITS;
    localparam int NEXT_W     = ((PROD_W > DRIVE_W) ? PROD_W : DRIVE_W) + 2;
    localparam logic signed [NEXT_W-1:0] DRIVE_MAX_S = NEXT_W'(DRIVE_MAX);

    logic signed [SUM_W-1:0]  prev_reg;
    logic                     first_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic [DRIVE_W-1:0]       drive_reg;

    logic                     stage_ready;
    logic signed [RATE_W-1:0] rate;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] gain_ext;
    logic signed [NEXT_W-1:0] drive_sum;
    logic [DRIVE_W-1:0]       drive_next;

    assign stage_ready = !prod_valid_reg || !res_full;
    assign sum_pop     = sum_valid && stage_ready;
    assign res_push    = prod_valid_reg && !res_full;

    always_comb
    begin
        // first block after reset compares against itself
        if (first_reg)
        begin
            rate = '0;
        end
        else
        begin
            rate = RATE_W'(prev_reg) - RATE_W'($signed(sum_data));
        end
        gain_ext  = signed'(PROD_W'(loop_gain));
        prod_next = PROD_W'(rate) * gain_ext;

        drive_sum = signed'(NEXT_W'(drive_reg)) + NEXT_W'(prod_reg);
        if (drive_sum > DRIVE_MAX_S)
        begin
            drive_next = DRIVE_W'(DRIVE_MAX);
        end
        else if (drive_sum[NEXT_W-1])
        begin
            drive_next = '0;
        end
        else
        begin
            drive_next = drive_sum[DRIVE_W-1:0];
        end
        res_data = drive_next[DAC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg      <= 1'b1;
            prev_reg       <= '0;
            prod_valid_reg <= 1'b0;
            drive_reg      <= DRIVE_W'(DRIVE_RESET);
        end
        else
        begin
            if (sum_pop)
            begin
                first_reg      <= 1'b0;
                prev_reg       <= $signed(sum_data);
                prod_valid_reg <= 1'b1;
            end
            else if (res_push)
            begin
                prod_valid_reg <= 1'b0;
            end
            if (res_push)
            begin
                drive_reg <= drive_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_pop)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/buffer_rate_clock_trim_core.sv]
// top level of the buffer rate clock trim block
//
// buffer-delay samples enter on a queue-style port: a transaction on push/full
// takes one signed 16-bit buffer_level. samples are summed over blocks of
// block_length (0 means 256); at the end of each block the drive level is
// moved by loop_gain times (previous sum - current sum), clamped to
// 0..DRIVE_MAX, and its low 12 bits appear as one dac_code on the result queue
// (empty/pop). samples that do not close a block give no result.
// throughput: one sample per cycle while full is low, and one result per cycle
// even with a block length of one while the result queue has room; the stages
// are the front accumulator, the rate/gain stage and the drive add/clamp stage.
// path: the front writes the closing block sum into the mid queue, the back
// stage registers rate times gain, and the clamped drive enters the result queue.
// reset: block_length 100, loop_gain 3, drive 2048, counters and sums cleared,
// result queue empty; the first block after reset gives a zero rate.
// receiver stall: up to four results wait in the result queue, one more in the
// back stage and two block sums between front and back; after that full rises
// and samples are held off until pop drains the queue.
// registers (apb, pready always high): 0x0 block_length, 0x4 loop_gain.
`default_nettype none

module buffer_rate_clock_trim_core #(
    parameter int DRIVE_MAX = 4095
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [brct_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [brct_pkg::DATA_W-1:0]         pwdata,
    output logic [brct_pkg::DATA_W-1:0]              prdata,
    output logic                                     pready,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [brct_pkg::LEVEL_W-1:0] buffer_level,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [brct_pkg::DAC_W-1:0]               dac_code
);

    import brct_pkg::*;

    logic [BLEN_W-1:0] block_length_reg;
    logic [GAIN_W-1:0] loop_gain_reg;
    logic              cfg_write;
    brct_reg_t         reg_sel;

    logic              mid_push;
    logic [SUM_W-1:0]  mid_wdata;
    logic              mid_full;
    logic              mid_pop;
    logic [SUM_W-1:0]  mid_rdata;
    logic              mid_empty;

    logic              res_push;
    logic [DAC_W-1:0]  res_data;
    logic              res_full;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = brct_reg_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        case (reg_sel)
            REG_BLOCK_LENGTH: prdata = DATA_W'(block_length_reg);
            REG_LOOP_GAIN:    prdata = DATA_W'(loop_gain_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= BLEN_RESET;
            loop_gain_reg    <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_BLOCK_LENGTH: block_length_reg <= pwdata[BLEN_W-1:0];
                REG_LOOP_GAIN:    loop_gain_reg    <= pwdata[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    brct_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .block_length (block_length_reg),
        .push         (push),
        .buffer_level (buffer_level),
        .full         (full),
        .sum_full     (mid_full),
        .sum_push     (mid_push),
        .sum_data     (mid_wdata)
    );

    brct_fifo #(
        .WIDTH (SUM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    brct_back #(
        .DRIVE_MAX (DRIVE_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .loop_gain (loop_gain_reg),
        .sum_valid (!mid_empty),
        .sum_data  (mid_rdata),
        .sum_pop   (mid_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    brct_fifo #(
        .WIDTH (DAC_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (dac_code),
        .empty (empty)
    );

endmodule

`default_nettype wire

[hw/rtl/brct_checker.sv]
// port-level checks for the buffer rate clock trim block, bound to the top level
`default_nettype none

module brct_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                psel,
    input wire logic                                penable,
    input wire logic                                pwrite,
    input wire logic [brct_pkg::ADDR_W-1:0]         paddr,
    input wire logic [brct_pkg::DATA_W-1:0]         pwdata,
    input wire logic [brct_pkg::DATA_W-1:0]         prdata,
    input wire logic                                pready,
    input wire logic                                empty,
    input wire logic                                pop,
    input wire logic [brct_pkg::DAC_W-1:0]          dac_code
);

    import brct_pkg::*;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;

    // a waiting result holds until it is taken
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(dac_code)))
        else $error("waiting result changed before pop");

    a_ready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

    // written block length reads back at the same address
    a_blen_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && paddr[ADDR_W-1:2] == REG_BLOCK_LENGTH) ##1
        (paddr[ADDR_W-1:2] == REG_BLOCK_LENGTH) |->
        (prdata[BLEN_W-1:0] == $past(pwdata[BLEN_W-1:0])))
        else $error("block_length readback mismatch");

    a_gain_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && paddr[ADDR_W-1:2] == REG_LOOP_GAIN) ##1
        (paddr[ADDR_W-1:2] == REG_LOOP_GAIN) |->
        (prdata[GAIN_W-1:0] == $past(pwdata[GAIN_W-1:0])))
        else $error("loop_gain readback mismatch");

endmodule

bind buffer_rate_clock_trim_core brct_checker u_brct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .empty        (empty),
    .pop          (pop),
    .dac_code     (dac_code)
);

`default_nettype wire

[verif/buffer_rate_clock_trim_core_tb.sv]
// self-checking testbench for buffer_rate_clock_trim_core: predicts each block's dac code and checks the result queue
module buffer_rate_clock_trim_core_tb;

    import brct_pkg::*;

    localparam int DRIVE_MAX    = 4095;
    localparam int ITEM_GOAL    = 1800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_SHOWN    = 10;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ADDR_W-1:0]           paddr;
    logic [DATA_W-1:0]           pwdata;
    logic [DATA_W-1:0]           prdata;
    logic                        pready;
    logic                        push;
    logic                        full;
    logic signed [LEVEL_W-1:0]   buffer_level;
    logic                        empty;
    logic                        pop;
    logic [DAC_W-1:0]            dac_code;

    // trim loop state as the block should hold it
    logic [BLEN_W-1:0]           trim_blen;
    logic [GAIN_W-1:0]           trim_gain;
    int                          blk_count;
    int                          blk_sum;
    int                          last_sum;
    bit                          first_blk;
    int                          drive_lvl;

    logic [DAC_W-1:0]            expected_dac[$];
    int                          errors;
    int                          items_sent;
    bit                          tx_nogap;
    bit                          rx_nostall;
    int                          rx_hold;
    logic signed [LEVEL_W-1:0]   level_center;

    buffer_rate_clock_trim_core #(
        .DRIVE_MAX(DRIVE_MAX)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .push(push),
        .full(full),
        .buffer_level(buffer_level),
        .empty(empty),
        .pop(pop),
        .dac_code(dac_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= MAX_SHOWN)
        begin
            $display("%s", msg);
        end
    endfunction

    // one sample into the block sum; a closed block yields the next dac code
    function automatic void predict_trim(input logic signed [LEVEL_W-1:0] lvl);
        int     lim;
        longint rate_val;
        longint next_drive;
        lim = (trim_blen == 0) ? 256 : int'(trim_blen);
        blk_sum += int'(lvl);
        blk_count++;
        if (blk_count < lim)
        begin
            return;
        end
        if (first_blk)
        begin
            first_blk = 1'b0;
            last_sum  = blk_sum;
        end
        rate_val   = longint'(last_sum) - longint'(blk_sum);
        last_sum   = blk_sum;
        blk_sum    = 0;
        blk_count  = 0;
        next_drive = longint'(drive_lvl) + longint'(trim_gain) * rate_val;
        if (next_drive > DRIVE_MAX)
        begin
            next_drive = DRIVE_MAX;
        end
        else if (next_drive < 0)
        begin
            next_drive = 0;
        end
        drive_lvl = int'(next_drive);
        expected_dac.push_back(DAC_W'(drive_lvl));
    endfunction

    function automatic logic signed [LEVEL_W-1:0] draw_level(input bit calm);
        logic signed [LEVEL_W-1:0] v;
        if (calm)
        begin
            v = LEVEL_W'(int'(level_center) + int'($urandom_range(0, 6)) - 3);
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: v = 16'sh7FFF;
                1: v = 16'sh8000;
                2: v = LEVEL_W'(int'(level_center) + int'($urandom_range(0, 6)) - 3);
                default: v = LEVEL_W'($urandom);
            endcase
        end
        return v;
    endfunction

    // field value with random junk above the field bits half the time
    function automatic logic [DATA_W-1:0] reg_word(input int v, input int w);
        logic [DATA_W-1:0] word;
        word = $urandom_range(0, 1) ? DATA_W'($urandom) : '0;
        word = ((word >> w) << w) | DATA_W'(v);
        return word;
    endfunction

    // result side: check each accepted transaction, then pick the next stall
    initial
    begin
        pop     <= 1'b0;
        rx_hold = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
            begin
                pop <= 1'b0;
            end
            else
            begin
                if (pop && !empty)
                begin
                    if (expected_dac.size() == 0)
                    begin
                        flag_error($sformatf("dac_code %0d arrived with no result due", dac_code));
                    end
                    else if (dac_code !== expected_dac[0])
                    begin
                        flag_error($sformatf("dac_code mismatch: expected %0d actual %0d",
                                             expected_dac[0], dac_code));
                        void'(expected_dac.pop_front());
                    end
                    else
                    begin
                        void'(expected_dac.pop_front());
                    end
                    rx_hold = rx_nostall ? 0 : $urandom_range(0, 6);
                end
                if (rx_hold > 0)
                begin
                    rx_hold--;
                    pop <= 1'b0;
                end
                else
                begin
                    pop <= 1'b1;
                end
            end
        end
    end

    task automatic send_level(input logic signed [LEVEL_W-1:0] lvl);
        int gap;
        gap = tx_nogap ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        buffer_level <= lvl;
        do
            @(posedge clk);
        while (full);
        predict_trim(lvl);
        items_sent++;
    endtask

    // drop push and let every pending result and any in-flight sample drain
    task automatic settle();
        push <= 1'b0;
        while (expected_dac.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_reg(input brct_reg_t idx, input int expect_val);
        logic [DATA_W-1:0] rd;
        int                w;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd      = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        w = (idx == REG_BLOCK_LENGTH) ? BLEN_W : GAIN_W;
        if ((rd & ((DATA_W'(1) << w) - 1)) !== DATA_W'(expect_val))
        begin
            flag_error($sformatf("register %s readback: expected %0d actual %0d",
                                 idx.name(), expect_val, rd));
        end
    endtask

    task automatic write_reg(input brct_reg_t idx, input logic [DATA_W-1:0] val);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BLOCK_LENGTH: trim_blen = val[BLEN_W-1:0];
            REG_LOOP_GAIN:    trim_gain = val[GAIN_W-1:0];
            default:          ;
        endcase
        @(posedge clk);
        check_reg(idx, (idx == REG_BLOCK_LENGTH) ? int'(trim_blen) : int'(trim_gain));
    endtask

    // defaults after reset; the first block of 100 must give a zero rate
    task automatic test_reset_defaults();
        check_reg(REG_BLOCK_LENGTH, int'(BLEN_RESET));
        check_reg(REG_LOOP_GAIN, int'(GAIN_RESET));
        level_center = $urandom;
        repeat (200) send_level(draw_level(1'b1));
    endtask

    // single-sample blocks with full-scale swings drive both clamps
    task automatic test_clamp_extremes();
        write_reg(REG_BLOCK_LENGTH, reg_word(1, BLEN_W));
        write_reg(REG_LOOP_GAIN, 32'hA5A5_A50F);
        send_level(16'sh7FFF);
        send_level(16'sh8000);
        send_level(16'sh7FFF);
        send_level(16'sh0000);
        send_level(16'sh8000);
        send_level(-16'sd1);
        send_level(16'sd1);
    endtask

    task automatic test_gain_zero();
        write_reg(REG_LOOP_GAIN, reg_word(0, GAIN_W));
        write_reg(REG_BLOCK_LENGTH, reg_word(2, BLEN_W));
        send_level(16'sh8000);
        send_level(16'sh7FFF);
        send_level(16'sh5555);
        send_level(16'shAAAA);
    endtask

    // block length moved down past the samples already taken, then up
    task automatic test_block_length_change();
        write_reg(REG_LOOP_GAIN, reg_word(1, GAIN_W));
        write_reg(REG_BLOCK_LENGTH, reg_word(10, BLEN_W));
        repeat (6) send_level(LEVEL_W'($urandom_range(0, 200)));
        write_reg(REG_BLOCK_LENGTH, reg_word(3, BLEN_W));
        send_level(16'sd40);
        write_reg(REG_BLOCK_LENGTH, reg_word(4, BLEN_W));
        repeat (2) send_level(-16'sd7);
        write_reg(REG_BLOCK_LENGTH, reg_word(9, BLEN_W));
        repeat (7) send_level(16'sd3);
    endtask

    task automatic test_random_blocks();
        int pick;
        int blen;
        int span;
        int gain_val;
        int n;
        bit calm;
        while (items_sent < ITEM_GOAL)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                blen = 0;
            else if (pick == 1)
                blen = 255;
            else if (pick < 5)
                blen = $urandom_range(13, 60);
            else
                blen = $urandom_range(1, 12);
            span = (blen == 0) ? 256 : blen;
            case ($urandom_range(0, 5))
                0:       gain_val = 0;
                1:       gain_val = 15;
                default: gain_val = $urandom_range(0, 15);
            endcase
            write_reg(REG_BLOCK_LENGTH, reg_word(blen, BLEN_W));
            write_reg(REG_LOOP_GAIN, reg_word(gain_val, GAIN_W));
            calm         = ($urandom_range(0, 4) != 0);
            level_center = $urandom;
            tx_nogap     = ($urandom_range(0, 3) == 0);
            rx_nostall   = ($urandom_range(0, 3) == 0);
            n = span * ((span > 60) ? $urandom_range(1, 2) : $urandom_range(2, 8));
            // a partial tail leaves a block open across the next length change
            if ($urandom_range(0, 2) == 0)
                n += $urandom_range(0, span - 1);
            if (n > ITEM_GOAL - items_sent)
                n = ITEM_GOAL - items_sent;
            repeat (n) send_level(draw_level(calm));
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        push         <= 1'b0;
        buffer_level <= '0;
        trim_blen    = BLEN_RESET;
        trim_gain    = GAIN_RESET;
        blk_count    = 0;
        blk_sum      = 0;
        last_sum     = 0;
        first_blk    = 1'b1;
        drive_lvl    = DRIVE_RESET;
        errors       = 0;
        items_sent   = 0;
        tx_nogap     = 1'b0;
        rx_nostall   = 1'b0;
        level_center = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_clamp_extremes();
        test_gain_zero();
        test_block_length_change();
        test_random_blocks();
        settle();
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
